/* src/sob_pkg.sv */
// Shared types, constants and the arctangent table for the Sobel gradient block.
// No dependencies; imported by the angle unit and the top level.
`default_nettype none
package sob_pkg;

   localparam int PIX_W   = 8;
   localparam int GRAD_W  = 11;
   localparam int ANG_W   = 10;
   localparam int DIM_W   = 11;
   localparam int CMP_W   = 13;
   localparam int CORD_W  = 26;
   localparam int Z_W     = 19;
   localparam int STEP_W  = 4;
   localparam int STEPS   = 16;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [DIM_W-1:0] HEIGHT_MAX   = 11'd1024;
   localparam logic [DIM_W-1:0] DIM_MIN      = 11'd3;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic signed [GRAD_W-1:0] grad_type;
   typedef logic signed [ANG_W-1:0]  angle_type;

   // atan(2^-i) in units of pi/131072.
   function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      begin
         case (idx)
            4'd0:    v = 19'sd32768;
            4'd1:    v = 19'sd19344;
            4'd2:    v = 19'sd10221;
            4'd3:    v = 19'sd5188;
            4'd4:    v = 19'sd2604;
            4'd5:    v = 19'sd1303;
            4'd6:    v = 19'sd652;
            4'd7:    v = 19'sd326;
            4'd8:    v = 19'sd163;
            4'd9:    v = 19'sd81;
            4'd10:   v = 19'sd41;
            4'd11:   v = 19'sd20;
            4'd12:   v = 19'sd10;
            4'd13:   v = 19'sd5;
            4'd14:   v = 19'sd3;
            default: v = 19'sd1;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

/* src/sob_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/sob_angle.sv */
// Iterative vectoring CORDIC: one rotation step per cycle, sixteen steps.
// Depends on sob_pkg for widths and the arctangent table.
`default_nettype none
module sob_angle
   import sob_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire grad_type  grad_x,
   input  wire grad_type  grad_y,
   output logic           done,
   output angle_type      angle
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic                     neg_ff, neg_in;
   logic                     gx_zero_ff, gx_zero_in;
   logic                     gy_zero_ff, gy_zero_in;
   logic                     gy_pos_ff, gy_pos_in;
   logic [GRAD_W-1:0]        abs_x, abs_y;
   logic signed [CORD_W-1:0] dx, dy;
   logic signed [Z_W-1:0]    z_clip;
   logic [Z_W-1:0]           k_sum;
   logic [8:0]               k_mag;

   assign abs_x = grad_x[GRAD_W-1] ? GRAD_W'(-grad_x) : grad_x;
   assign abs_y = grad_y[GRAD_W-1] ? GRAD_W'(-grad_y) : grad_y;
   assign dx    = y_ff >>> step_ff;
   assign dy    = x_ff >>> step_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      neg_in     = neg_ff;
      gx_zero_in = gx_zero_ff;
      gy_zero_in = gy_zero_ff;
      gy_pos_in  = gy_pos_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         x_in       = CORD_W'({abs_x, 12'b0});
         y_in       = CORD_W'({abs_y, 12'b0});
         z_in       = '0;
         neg_in     = grad_x[GRAD_W-1] ^ grad_y[GRAD_W-1];
         gx_zero_in = (grad_x == '0);
         gy_zero_in = (grad_y == '0);
         gy_pos_in  = !grad_y[GRAD_W-1] && (grad_y != '0);
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_step(step_ff);
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_step(step_ff);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      neg_ff     <= neg_in;
      gx_zero_ff <= gx_zero_in;
      gy_zero_ff <= gy_zero_in;
      gy_pos_ff  <= gy_pos_in;
   end

   // Round to units of pi/512 and cap at a quarter turn.
   assign z_clip = z_ff[Z_W-1] ? '0 : z_ff;
   assign k_sum  = Z_W'(z_clip) + Z_W'(128);
   assign k_mag  = (k_sum[Z_W-1:8] > 11'd256) ? 9'd256 : k_sum[16:8];

   always_comb begin
      if (gx_zero_ff) begin
         if (gy_zero_ff) begin
            angle = '0;
         end else if (gy_pos_ff) begin
            angle = 10'sd256;
         end else begin
            angle = -10'sd256;
         end
      end else if (gy_zero_ff) begin
         angle = '0;
      end else if (neg_ff) begin
         angle = ANG_W'(-$signed({1'b0, k_mag}));
      end else begin
         angle = ANG_W'($signed({1'b0, k_mag}));
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

/* src/sobel_gradient_magnitude_direction_top.sv */
// Top level of the 3x3 Sobel gradient block: position tracking, line stores,
// window and output register. Depends on sob_pkg, sob_ram and sob_angle.
`default_nettype none
// Channel   Direction  Ports                                   Meaning
// req       in         req_valid/req_stall, pixel, filler      one pixel or filler
// rsp       out        rsp_valid/rsp_stall, grad_x .. last     one gradient result
// csr       in         csr_write_enable, csr_index, csr_data   image width/height
//
// Each request is accepted with the line store read; a dropped filler needs
// nothing more. Any other request then forms the gradients and, bar the final
// drain one, updates the window; one that yields a result goes on through the
// sixteen CORDIC steps, waits for the angle unit to flag completion and loads
// the output register. Reset is synchronous; it clears the window, the position
// and the control state. The line stores are not cleared. A stalled result sits
// in the output register while the next request is accepted and processed; the
// block only holds a new result back until the previous one has been taken.
module sobel_gradient_magnitude_direction_top
   import sob_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pix_type          req_pixel,
   input  wire logic             req_filler,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output grad_type              rsp_grad_x,
   output grad_type              rsp_grad_y,
   output logic [GRAD_W-1:0]     rsp_magnitude,
   output angle_type             rsp_angle,
   output logic                  rsp_last_of_frame,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [DIM_W-1:0] csr_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CALC  = 2'd1;
   localparam logic [1:0] S_ANGLE = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [AW-1:0]    col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;

   // Clamped frame size.
   logic [CMP_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [CMP_W-1:0] h_plus1;

   // Position of the accepted request after the mid-frame fixups.
   logic [CMP_W-1:0] c_norm, r_norm, c_next;
   logic             drop;
   logic             accept;

   // Per-request flags held while the request is worked on.
   logic [AW-1:0]    cur_col_ff;
   pix_type          cur_pix_ff;
   logic             r_lt_h_ff, r_is1_ff, r_ge1_ff, r_ge2_ff, r_last_ff;
   logic             c_is0_ff, c_is1_ff;

   pix_type          win_ff [3][3];
   pix_type          col_data [3];
   pix_type          up_rd, lo_rd;
   pix_type          tl, tm, tb, ml, mb, rl, rm, rb;
   logic             emit;
   logic             last_ff;
   grad_type         gx_in, gy_in, gx_ff, gy_ff;
   logic [GRAD_W-1:0] abs_gx, abs_gy;

   logic             cord_done;
   angle_type        cord_angle;

   logic             out_free;
   logic             rsp_valid_ff;
   grad_type         out_gx_ff, out_gy_ff;
   logic [GRAD_W-1:0] out_mag_ff;
   angle_type        out_ang_ff;
   logic             out_last_ff;

   // Register writes take effect at once; the user keeps them to idle, unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < DIM_MIN) begin
         w_eff = CMP_W'(DIM_MIN);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff < DIM_MIN) begin
         h_eff = DIM_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         h_eff = HEIGHT_MAX;
      end else begin
         h_eff = height_ff;
      end
   end

   assign h_plus1 = CMP_W'(h_eff) + CMP_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // A position left behind by a register change wraps to the next row, and a
   // position past the final drain request restarts the frame.
   always_comb begin
      c_norm = CMP_W'(col_ff);
      r_norm = CMP_W'(row_ff);
      if (c_norm >= w_eff) begin
         c_norm = '0;
         r_norm = r_norm + CMP_W'(1);
      end
      if ((r_norm > h_plus1) || ((r_norm == h_plus1) && (c_norm != '0))) begin
         c_norm = '0;
         r_norm = '0;
      end
      drop   = req_filler && (r_norm < CMP_W'(h_eff));
      c_next = c_norm + CMP_W'(1);
      col_in = AW'(c_norm);
      row_in = DIM_W'(r_norm);
      if (!drop) begin
         if (r_norm == h_plus1) begin
            col_in = '0;
            row_in = '0;
         end else if (c_next >= w_eff) begin
            col_in = '0;
            row_in = DIM_W'(r_norm + CMP_W'(1));
         end else begin
            col_in = AW'(c_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_col_ff <= AW'(c_norm);
         cur_pix_ff <= req_pixel;
         r_lt_h_ff  <= (r_norm < CMP_W'(h_eff));
         r_is1_ff   <= (r_norm == CMP_W'(1));
         r_ge1_ff   <= (r_norm >= CMP_W'(1));
         r_ge2_ff   <= (r_norm >= CMP_W'(2));
         r_last_ff  <= (r_norm == h_plus1);
         c_is0_ff   <= (c_norm == '0);
         c_is1_ff   <= (c_norm == CMP_W'(1));
      end
   end

   // Line stores hold rows r-2 (upper) and r-1 (lower). The read is issued
   // on acceptance and the write-back lands in the following cycle, before
   // any other request can read, so no forwarding is needed.
   sob_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   ((state_ff == S_CALC) && r_lt_h_ff),
      .wr_addr (cur_col_ff),
      .wr_data (lo_rd),
      .rd_addr (AW'(c_norm)),
      .rd_data (up_rd)
   );

   sob_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   ((state_ff == S_CALC) && r_lt_h_ff),
      .wr_addr (cur_col_ff),
      .wr_data (cur_pix_ff),
      .rd_addr (AW'(c_norm)),
      .rd_data (lo_rd)
   );

   // New column entering the window; the top border reflects on row one and
   // the bottom border reflects during the drain row.
   always_comb begin
      col_data[1] = lo_rd;
      col_data[2] = r_lt_h_ff ? cur_pix_ff : up_rd;
      col_data[0] = r_is1_ff ? col_data[2] : up_rd;
   end

   // Column zero finishes the previous row with the right edge reflected.
   // Elsewhere the left edge reflects on column one.
   always_comb begin
      if (c_is0_ff) begin
         tl = win_ff[1][0]; ml = win_ff[1][1]; rl = win_ff[1][2];
         tm = win_ff[2][0]; mb = win_ff[2][2];
         tb = win_ff[1][0]; rm = win_ff[1][1]; rb = win_ff[1][2];
         emit = r_ge2_ff;
      end else begin
         if (c_is1_ff) begin
            tl = col_data[0]; ml = col_data[1]; rl = col_data[2];
         end else begin
            tl = win_ff[1][0]; ml = win_ff[1][1]; rl = win_ff[1][2];
         end
         tm = win_ff[2][0]; mb = win_ff[2][2];
         tb = col_data[0]; rm = col_data[1]; rb = col_data[2];
         emit = r_ge1_ff;
      end
      // tl/ml/rl: left column top/mid/bottom; tb/rm/rb: right column.
      gx_in = $signed(GRAD_W'({3'b0, tl}) + GRAD_W'({2'b0, ml, 1'b0}) + GRAD_W'({3'b0, rl}))
            - $signed(GRAD_W'({3'b0, tb}) + GRAD_W'({2'b0, rm, 1'b0}) + GRAD_W'({3'b0, rb}));
      gy_in = $signed(GRAD_W'({3'b0, tl}) + GRAD_W'({2'b0, tm, 1'b0}) + GRAD_W'({3'b0, tb}))
            - $signed(GRAD_W'({3'b0, rl}) + GRAD_W'({2'b0, mb, 1'b0}) + GRAD_W'({3'b0, rb}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if ((state_ff == S_CALC) && !r_last_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= col_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         last_ff <= r_last_ff;
      end
   end

   sob_angle u_angle (
      .clock  (clock),
      .reset  (reset),
      .start  ((state_ff == S_CALC) && emit),
      .grad_x (gx_in),
      .grad_y (gy_in),
      .done   (cord_done),
      .angle  (cord_angle)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !drop) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = emit ? S_ANGLE : S_IDLE;
         end
         S_ANGLE: begin
            if (cord_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign abs_gx = gx_ff[GRAD_W-1] ? GRAD_W'(-gx_ff) : gx_ff;
   assign abs_gy = gy_ff[GRAD_W-1] ? GRAD_W'(-gy_ff) : gy_ff;

   // Output register; the angle is captured while the state waits here.
   logic load_out;
   assign load_out = (state_ff == S_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_gx_ff   <= gx_ff;
         out_gy_ff   <= gy_ff;
         out_mag_ff  <= abs_gx + abs_gy;
         out_ang_ff  <= cord_angle;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_grad_x        = out_gx_ff;
   assign rsp_grad_y        = out_gy_ff;
   assign rsp_magnitude     = out_mag_ff;
   assign rsp_angle         = out_ang_ff;
   assign rsp_last_of_frame = out_last_ff;

`ifndef SYNTHESIS
   a_calc_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> ($past(state_ff) == S_IDLE))
      else $error("window update without a preceding accept");

   a_done_in_angle: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> (state_ff == S_ANGLE))
      else $error("angle unit finished outside the angle wait");

   a_mag_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_mag_ff ==
         (out_gx_ff[GRAD_W-1] ? GRAD_W'(-out_gx_ff) : out_gx_ff)
         + (out_gy_ff[GRAD_W-1] ? GRAD_W'(-out_gy_ff) : out_gy_ff)))
      else $error("magnitude does not match the gradients");

   a_flat_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_gy_ff == '0)) |-> (out_ang_ff == '0))
      else $error("flat gradient with nonzero angle");
`endif

endmodule
`default_nettype wire

/* bench/tb_sobel_gradient_magnitude_direction_top.sv */
// Self-checking bench for the 3x3 Sobel gradient block: streams whole frames of
// pixels, predicts every gradient result and compares it field by field.
// Depends on sob_pkg and the sobel_gradient_magnitude_direction_top RTL.
`default_nettype none
module tb_sobel_gradient_magnitude_direction_top
   import sob_pkg::*;
();

   typedef struct packed {
      pix_type pixel;
      logic    filler;
   } pixel_request_type;

   typedef struct packed {
      grad_type          grad_x;
      grad_type          grad_y;
      logic [GRAD_W-1:0] magnitude;
      angle_type         angle;
      logic              last_of_frame;
   } gradient_result_type;

   typedef logic [2:0][PIX_W-1:0] pixel_column_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 50;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pix_type           req_pixel = '0;
   logic              req_filler = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   grad_type          rsp_grad_x;
   grad_type          rsp_grad_y;
   logic [GRAD_W-1:0] rsp_magnitude;
   angle_type         rsp_angle;
   logic              rsp_last_of_frame;
   logic              csr_write_enable = 1'b0;
   logic              csr_index = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]  csr_data = '0;

   sobel_gradient_magnitude_direction_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pending requests for the driver, and the results still owed by the block.
   pixel_request_type   pending_pixels[$];
   gradient_result_type expected_gradients[$];

   int  sender_idle_pct   = 26;
   int  receiver_idle_pct = 77;
   bit  sender_hold       = 1'b0;
   logic req_taken        = 1'b0;
   int  mismatch_count    = 0;
   int  requests_accepted = 0;
   int  results_checked   = 0;
   int  frames_sent       = 0;
   int  quiet_cycles      = 0;

   // Shadow of the block's state, kept by the predictor.
   pix_type    upper_row[1024];
   pix_type    lower_row[1024];
   pixel_column_type win_left, win_centre, win_right;
   int unsigned col_pos, row_pos;
   logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
   logic [DIM_W-1:0] height_reg = HEIGHT_RESET;

   // Appends one request to the driver's queue.
   task automatic queue_request(input pixel_request_type rq);
      pending_pixels = {pending_pixels, rq};
   endtask

   // Appends one result to the list of results the block still owes.
   task automatic owe_result(input gradient_result_type res);
      expected_gradients = {expected_gradients, res};
   endtask

   // Angle of (gx, gy) in units of pi/512, by a 16-step vectoring CORDIC.
   function automatic int gradient_angle(input int gx, input int gy);
      longint x, y, z, dx, dy, k;
      longint steps[16] = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
                            163, 81, 41, 20, 10, 5, 3, 1};
      if (gx == 0) return (gy > 0) ? 256 : ((gy < 0) ? -256 : 0);
      if (gy == 0) return 0;
      x = longint'(gx < 0 ? -gx : gx) * 4096;
      y = longint'(gy < 0 ? -gy : gy) * 4096;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += steps[i];
         end else begin
            x -= dx; y += dy; z -= steps[i];
         end
      end
      if (z < 0) z = 0;
      k = (z + 128) >>> 8;
      if (k > 256) k = 256;
      return ((gx < 0) != (gy < 0)) ? -int'(k) : int'(k);
   endfunction

   // Index 0 of a column is its top pixel, index 2 its bottom pixel.
   function automatic gradient_result_type sobel_of(input pixel_column_type l,
                                                    input pixel_column_type c,
                                                    input pixel_column_type r,
                                                    input bit last);
      gradient_result_type res;
      int gx, gy;
      gx = (int'(l[0]) + 2 * int'(l[1]) + int'(l[2])) - (int'(r[0]) + 2 * int'(r[1]) + int'(r[2]));
      gy = (int'(l[0]) + 2 * int'(c[0]) + int'(r[0])) - (int'(l[2]) + 2 * int'(c[2]) + int'(r[2]));
      res.grad_x        = grad_type'(gx);
      res.grad_y        = grad_type'(gy);
      res.magnitude     = GRAD_W'((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy));
      res.angle         = angle_type'(gradient_angle(gx, gy));
      res.last_of_frame = last;
      return res;
   endfunction

   // Advances the shadow state by one accepted request and queues any result.
   task automatic predict_gradient(input pixel_request_type rq);
      int unsigned w, h, c, r;
      pixel_column_type fresh;
      w = width_reg;
      h = height_reg;
      if (w < 3) w = 3;
      if (w > 1024) w = 1024;
      if (h < 3) h = 3;
      if (h > 1024) h = 1024;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
         row_pos = 0;
         col_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      // A filler inside the frame is simply dropped.
      if (rq.filler && r < h) return;
      // Column 0 closes the previous row, its right edge reflected.
      if (c == 0 && r >= 2)
         owe_result(sobel_of(win_centre, win_right, win_centre, r == h + 1));
      if (r == h + 1) begin
         row_pos = 0;
         col_pos = 0;
         return;
      end
      fresh[0] = upper_row[c];
      fresh[1] = lower_row[c];
      fresh[2] = (r < h) ? rq.pixel : fresh[0];
      if (r == 1) fresh[0] = fresh[2];
      if (r < h) begin
         upper_row[c] = lower_row[c];
         lower_row[c] = rq.pixel;
      end
      win_left   = win_centre;
      win_centre = win_right;
      win_right  = fresh;
      if (c >= 1 && r >= 1)
         owe_result(sobel_of((c == 1) ? win_right : win_left, win_centre, win_right, 1'b0));
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch on result %0d: %s is %0d, expected %0d", results_checked, what, got,
               want);
   endtask

   // Driver: a new request goes out at the falling edge once the previous one is taken.
   always @(negedge clock) begin
      pixel_request_type rq;
      if (!reset && (!req_valid || req_taken)) begin
         if (!sender_hold && pending_pixels.size() > 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            rq = pending_pixels.pop_front();
            req_pixel  <= rq.pixel;
            req_filler <= rq.filler;
            req_valid  <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // Monitor: predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin
      gradient_result_type want;
      bit req_fire, rsp_fire;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      req_taken <= req_fire;
      if (req_fire) begin
         predict_gradient('{pixel: req_pixel, filler: req_filler});
         requests_accepted++;
      end
      if (rsp_fire) begin
         if (expected_gradients.size() == 0) begin
            report_mismatch("unexpected result, grad_x", rsp_grad_x, 0);
         end else begin
            want = expected_gradients.pop_front();
            if (rsp_grad_x !== want.grad_x) report_mismatch("grad_x", rsp_grad_x, want.grad_x);
            if (rsp_grad_y !== want.grad_y) report_mismatch("grad_y", rsp_grad_y, want.grad_y);
            if (rsp_magnitude !== want.magnitude)
               report_mismatch("magnitude", rsp_magnitude, want.magnitude);
            if (rsp_angle !== want.angle) report_mismatch("angle", rsp_angle, want.angle);
            if (rsp_last_of_frame !== want.last_of_frame)
               report_mismatch("last_of_frame", rsp_last_of_frame, want.last_of_frame);
         end
         results_checked++;
      end
      // The watchdog only counts cycles in which neither channel moves.
      if (req_fire || rsp_fire || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Register writes happen only at a falling edge while the block is idle.
   task automatic write_register(input logic index, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_data         = value;
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Waits until every queued request went out and every owed result came back.
   task automatic wait_drained();
      while (pending_pixels.size() > 0 || req_valid || expected_gradients.size() > 0)
         @(posedge clock);
   endtask

   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      return (v < 3) ? 3 : ((v > 1024) ? 1024 : int'(v));
   endfunction

   // Queues one frame plus its drain. The pattern picks how pixels are made so
   // that flat areas, pure horizontal and pure vertical edges all show up.
   // A nonzero pause_at makes the sender wait for all results at that pixel.
   task automatic queue_frame(input int w, input int h, input int pattern, input int pause_at);
      pixel_request_type rq;
      int level;
      level = $urandom_range(255);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            if (pause_at != 0 && y * w + x == pause_at) begin
               // Everything queued so far goes out first; then the sender sits
               // still until the block has returned every owed result.
               while (pending_pixels.size() > 0) @(posedge clock);
               sender_hold = 1'b1;
               while (req_valid || expected_gradients.size() > 0) @(posedge clock);
               sender_hold = 1'b0;
            end
            // Stray fillers inside the frame must be dropped without effect.
            if ($urandom_range(99) < 4)
               queue_request('{pixel: pix_type'($urandom), filler: 1'b1});
            case (pattern)
               0: rq.pixel = pix_type'($urandom);
               1: rq.pixel = $urandom_range(1) ? 8'hff : 8'h00;
               2: rq.pixel = pix_type'(level);
               3: rq.pixel = pix_type'(level + x * 37);
               4: rq.pixel = pix_type'(level + y * 53);
               default: rq.pixel = pix_type'(level + $urandom_range(6));
            endcase
            rq.filler = 1'b0;
            queue_request(rq);
         end
      end
      // Drain: one more row plus one request, as filler or as ignored pixels.
      for (int i = 0; i <= w; i++)
         queue_request('{pixel: pix_type'($urandom), filler: 1'($urandom)});
      frames_sent++;
   endtask

   task automatic run_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input int pattern, input int pause_at);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      queue_frame(clamp_dim(w), clamp_dim(h), pattern, pause_at);
   endtask

   initial begin
      int budget;
      col_pos = 0;
      row_pos = 0;
      win_left = '0;
      win_centre = '0;
      win_right = '0;
      for (int i = 0; i < 1024; i++) begin
         upper_row[i] = '0;
         lower_row[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frame: smallest size, pixels at both extremes, a filler
      // inside the frame, and a mix of fillers and ignored pixels in the drain.
      write_register(CSR_IMAGE_WIDTH, 11'd3);
      write_register(CSR_IMAGE_HEIGHT, 11'd3);
      queue_request('{pixel: 8'hff, filler: 1'b0});
      queue_request('{pixel: 8'h00, filler: 1'b0});
      queue_request('{pixel: 8'hff, filler: 1'b1});
      queue_request('{pixel: 8'hff, filler: 1'b0});
      queue_request('{pixel: 8'h00, filler: 1'b0});
      queue_request('{pixel: 8'h00, filler: 1'b0});
      queue_request('{pixel: 8'h00, filler: 1'b0});
      queue_request('{pixel: 8'hff, filler: 1'b0});
      queue_request('{pixel: 8'hff, filler: 1'b0});
      queue_request('{pixel: 8'hff, filler: 1'b0});
      queue_request('{pixel: 8'h5a, filler: 1'b0});
      queue_request('{pixel: 8'ha5, filler: 1'b1});
      queue_request('{pixel: 8'h00, filler: 1'b1});
      queue_request('{pixel: 8'hff, filler: 1'b0});
      frames_sent++;

      // Random frames, mostly small, in three idling phases.
      budget = 0;
      while (budget < 1000) begin
         if (budget < 350) begin
            sender_idle_pct = 26; receiver_idle_pct = 77;
         end else if (budget < 700) begin
            sender_idle_pct = 77; receiver_idle_pct = 26;
         end else begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         begin
            logic [DIM_W-1:0] w, h;
            w = DIM_W'($urandom_range(0, 24));
            h = DIM_W'($urandom_range(0, 8));
            run_frame(w, h, $urandom_range(5),
                      (frames_sent == 5) ? clamp_dim(w) * clamp_dim(h) / 2 : 0);
            budget += clamp_dim(w) * clamp_dim(h) + clamp_dim(w) + 1;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d frames (3 to 24 wide, 3 to 8 tall), %0d requests, %0d results",
               frames_sent, requests_accepted, results_checked);
      $display("idling phases: sender 26/receiver 77, sender 77/receiver 26, none");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
